FILE: src/spm_pkg.sv
`timescale 1ns / 1ps
package spm_pkg;
   localparam int MAX_TERMS     = 8;
   localparam int PRODUCT_DEPTH = 64;
   localparam int OUT_LIMIT     = 64;
   localparam int PROD_CAP      = (PRODUCT_DEPTH < OUT_LIMIT) ? PRODUCT_DEPTH : OUT_LIMIT;

   localparam int COEF_W  = 16;
   localparam int EXP_W   = 15;
   localparam int SUM_W   = 38;
   localparam int SEXP_W  = 16;
   localparam int PROD_W  = SUM_W + SEXP_W;

   localparam int TIDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int TCNT_W  = $clog2(MAX_TERMS + 1);
   localparam int PADDR_W = (PROD_CAP > 1) ? $clog2(PROD_CAP) : 1;
   localparam int PCNT_W  = $clog2(PROD_CAP + 1);

   localparam int REQ_DATA_W = ((COEF_W + EXP_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SUM_W + SEXP_W + 7) / 8) * 8;

   localparam logic CMD_FIRST  = 1'b0;
   localparam logic CMD_SECOND = 1'b1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FORM,
      ST_SCAN,
      ST_EMIT
   } state_type;
endpackage

FILE: src/spm_ram.sv
`timescale 1ns / 1ps
module spm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: src/sparse_polynomial_multiply.sv
`timescale 1ns / 1ps
// Sparse polynomial multiplier. Terms of the first (tuser 0) and second (tuser 1)
// polynomial are loaded one per cycle, up to 8 each; extra terms are dropped and
// reported on every result through rsp_tuser. The transfer with tlast on the second
// polynomial starts the product: with F and S stored terms, the F*S products are
// formed into a 64 entry scratch RAM through one 16x16 multiplier, then for each
// of the D distinct exponents all P = F*S products are scanned through the RAM
// read port before the result is handed over. Results come out in descending
// exponent order, one per exponent, tlast on the last; req_tready is low until it
// is taken. If either polynomial is empty, no result is given and the stores are
// simply cleared.
module sparse_polynomial_multiply (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // coefficient [15:0], exponent [30:16], zero pad
   input  logic [spm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command [0]
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sum_coefficient [37:0], sum_exponent [53:38], zero pad
   output logic [spm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // terms_dropped [0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import spm_pkg::*;

   state_type state_ff, state_in;

   logic signed [COEF_W-1:0] first_coefs_ff [MAX_TERMS];
   logic [EXP_W-1:0]         first_exps_ff  [MAX_TERMS];
   logic signed [COEF_W-1:0] second_coefs_ff [MAX_TERMS];
   logic [EXP_W-1:0]         second_exps_ff  [MAX_TERMS];

   logic [TCNT_W-1:0] first_count_ff, first_count_in;
   logic [TCNT_W-1:0] second_count_ff, second_count_in;
   logic              overflow_ff, overflow_in;
   logic              dropped_ff, dropped_in;
   logic [TIDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [PCNT_W-1:0] n_ff, n_in, rd_ff, rd_in;
   logic              vld_ff, vld_in, lastrd_ff, lastrd_in;
   logic [SEXP_W-1:0] cur_ff, cur_in, nxt_ff, nxt_in;
   logic              found_ff, found_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic                    wr_first, wr_second;
   logic                    ram_wr;
   logic [PROD_W-1:0]       ram_wdata, ram_rdata;
   logic [PADDR_W-1:0]      ram_raddr;
   logic signed [2*COEF_W-1:0] prod;
   logic [SEXP_W-1:0]       pexp;
   logic signed [SUM_W-1:0] rd_coef;
   logic [SEXP_W-1:0]       rd_exp;
   logic signed [SUM_W:0]   acc;

   logic signed [COEF_W-1:0] in_coef;
   logic [EXP_W-1:0]         in_exp;
   logic                     accept;

   assign in_coef = req_tdata[COEF_W-1:0];
   assign in_exp  = req_tdata[COEF_W+EXP_W-1:COEF_W];
   assign accept  = req_tvalid && req_tready;

   // shared multiplier and exponent adder
   assign prod = first_coefs_ff[i_ff] * second_coefs_ff[j_ff];
   assign pexp = SEXP_W'(first_exps_ff[i_ff]) + SEXP_W'(second_exps_ff[j_ff]);
   assign ram_wdata = {pexp, SUM_W'(prod)};
   assign ram_raddr = rd_ff[PADDR_W-1:0];
   assign rd_coef = ram_rdata[SUM_W-1:0];
   assign rd_exp  = ram_rdata[PROD_W-1:SUM_W];
   assign acc = {sum_ff[SUM_W-1], sum_ff} + {rd_coef[SUM_W-1], rd_coef};

   spm_ram #(.WIDTH(PROD_W), .DEPTH(PROD_CAP)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (n_ff[PADDR_W-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // term stores
   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_coefs_ff[first_count_ff[TIDX_W-1:0]] <= in_coef;
         first_exps_ff[first_count_ff[TIDX_W-1:0]]  <= in_exp;
      end
      if (wr_second) begin
         second_coefs_ff[second_count_ff[TIDX_W-1:0]] <= in_coef;
         second_exps_ff[second_count_ff[TIDX_W-1:0]]  <= in_exp;
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         vld_ff          <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         vld_ff          <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dropped_ff <= dropped_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      n_ff       <= n_in;
      rd_ff      <= rd_in;
      lastrd_ff  <= lastrd_in;
      cur_ff     <= cur_in;
      nxt_ff     <= nxt_in;
      found_ff   <= found_in;
      sum_ff     <= sum_in;
   end

   // sequencer
   always_comb begin
      logic [TCNT_W-1:0] sc_new;
      logic              ovf_new;
      logic              issue;
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      dropped_in      = dropped_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      n_in            = n_ff;
      rd_in           = rd_ff;
      vld_in          = 1'b0;
      lastrd_in       = 1'b0;
      cur_in          = cur_ff;
      nxt_in          = nxt_ff;
      found_in        = found_ff;
      sum_in          = sum_ff;
      wr_first        = 1'b0;
      wr_second       = 1'b0;
      ram_wr          = 1'b0;
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      sc_new          = second_count_ff;
      ovf_new         = overflow_ff;
      issue           = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (accept) begin
               if (req_tuser == CMD_FIRST) begin
                  if (first_count_ff < TCNT_W'(MAX_TERMS)) begin
                     wr_first       = 1'b1;
                     first_count_in = first_count_ff + 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  if (second_count_ff < TCNT_W'(MAX_TERMS)) begin
                     wr_second = 1'b1;
                     sc_new    = second_count_ff + 1'b1;
                  end else begin
                     ovf_new = 1'b1;
                  end
                  second_count_in = sc_new;
                  overflow_in     = ovf_new;
                  if (req_tlast) begin
                     if (first_count_ff == '0 || sc_new == '0) begin
                        first_count_in  = '0;
                        second_count_in = '0;
                        overflow_in     = 1'b0;
                     end else begin
                        state_in   = ST_FORM;
                        dropped_in = ovf_new;
                        i_in       = '0;
                        j_in       = '0;
                        n_in       = '0;
                        cur_in     = '0;
                     end
                  end
               end
            end
         end
         ST_FORM: begin
            // one product a cycle, first-term major; track the top exponent
            if (n_ff < PCNT_W'(PROD_CAP)) begin
               ram_wr = 1'b1;
               n_in   = n_ff + 1'b1;
               if (n_ff == '0 || pexp > cur_ff) begin
                  cur_in = pexp;
               end
            end else begin
               dropped_in = 1'b1;
            end
            if (TCNT_W'(j_ff) + 1'b1 == second_count_ff) begin
               j_in = '0;
               if (TCNT_W'(i_ff) + 1'b1 == first_count_ff) begin
                  state_in = ST_SCAN;
                  rd_in    = '0;
                  sum_in   = '0;
                  found_in = 1'b0;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            // read every product: sum the current exponent, find the next lower one
            issue     = (rd_ff < n_ff);
            vld_in    = issue;
            lastrd_in = issue && (rd_ff + 1'b1 == n_ff);
            if (issue) begin
               rd_in = rd_ff + 1'b1;
            end
            if (vld_ff) begin
               if (rd_exp == cur_ff) begin
                  if (acc[SUM_W] != acc[SUM_W-1]) begin
                     sum_in = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
                  end else begin
                     sum_in = acc[SUM_W-1:0];
                  end
               end else if (rd_exp < cur_ff && (!found_ff || rd_exp > nxt_ff)) begin
                  nxt_in   = rd_exp;
                  found_in = 1'b1;
               end
               if (lastrd_ff) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (!found_ff) begin
                  state_in        = ST_LOAD;
                  first_count_in  = '0;
                  second_count_in = '0;
                  overflow_in     = 1'b0;
               end else begin
                  state_in = ST_SCAN;
                  cur_in   = nxt_ff;
                  rd_in    = '0;
                  sum_in   = '0;
                  found_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // result payload
   assign rsp_tdata = {{(RSP_DATA_W-PROD_W){1'b0}}, cur_ff, sum_ff};
   assign rsp_tuser = dropped_ff;
   assign rsp_tlast = !found_ff;
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import spm_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 6000;

   typedef struct packed {
      logic signed [SUM_W-1:0] coef_sum;
      logic [SEXP_W-1:0]       exp_sum;
      logic                    final_term;
      logic                    dropped;
   } product_term_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   // idle rates in percent, and the long receiver hold-off
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int holdoff_cycles = 0;

   // predictor state
   logic signed [COEF_W-1:0] first_coef_q[$];
   logic [EXP_W-1:0]         first_exp_q[$];
   logic signed [COEF_W-1:0] second_coef_q[$];
   logic [EXP_W-1:0]         second_exp_q[$];
   logic                     drop_seen = 1'b0;

   product_term_type expected_terms[$];
   int mismatch_count = 0;
   int result_count = 0;
   int item_count = 0;
   int product_count = 0;
   int idle_cycles = 0;

   sparse_polynomial_multiply dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // multiply, sort by descending exponent, merge equal exponents
   task automatic form_product();
      logic signed [SUM_W-1:0] coefs[$];
      logic [SEXP_W-1:0]       exps[$];
      logic signed [SUM_W-1:0] c;
      logic [SEXP_W-1:0]       e;
      logic signed [SUM_W:0]   sum;
      logic                    dropped;
      int k;
      int i;
      product_term_type t;
      dropped = drop_seen;
      foreach (first_coef_q[a]) begin
         foreach (second_coef_q[b]) begin
            if (coefs.size() >= PROD_CAP) begin
               dropped = 1'b1;
            end else begin
               coefs.push_back(SUM_W'(32'(first_coef_q[a]) * 32'(second_coef_q[b])));
               exps.push_back(SEXP_W'(first_exp_q[a]) + SEXP_W'(second_exp_q[b]));
            end
         end
      end
      for (i = 1; i < coefs.size(); i++) begin
         c = coefs[i];
         e = exps[i];
         k = i;
         while (k > 0 && exps[k-1] < e) begin
            coefs[k] = coefs[k-1];
            exps[k] = exps[k-1];
            k--;
         end
         coefs[k] = c;
         exps[k] = e;
      end
      i = 0;
      while (i < coefs.size()) begin
         sum = coefs[i];
         e = exps[i];
         i++;
         while (i < coefs.size() && exps[i] == e) begin
            sum = sum + coefs[i];
            // saturate to the 38-bit signed range
            if (sum > $signed({2'b00, {(SUM_W-1){1'b1}}})) sum = {2'b00, {(SUM_W-1){1'b1}}};
            if (sum < $signed({2'b11, {(SUM_W-1){1'b0}}})) sum = {2'b11, {(SUM_W-1){1'b0}}};
            i++;
         end
         t.coef_sum = sum[SUM_W-1:0];
         t.exp_sum = e;
         t.final_term = (i >= coefs.size());
         t.dropped = dropped;
         expected_terms.push_back(t);
      end
      first_coef_q.delete();
      first_exp_q.delete();
      second_coef_q.delete();
      second_exp_q.delete();
      drop_seen = 1'b0;
      product_count++;
   endtask

   task automatic predict_term(logic cmd, logic signed [COEF_W-1:0] coef,
                               logic [EXP_W-1:0] exponent, logic last);
      if (cmd == CMD_FIRST) begin
         if (first_coef_q.size() < MAX_TERMS) begin
            first_coef_q.push_back(coef);
            first_exp_q.push_back(exponent);
         end else begin
            drop_seen = 1'b1;
         end
      end else begin
         if (second_coef_q.size() < MAX_TERMS) begin
            second_coef_q.push_back(coef);
            second_exp_q.push_back(exponent);
         end else begin
            drop_seen = 1'b1;
         end
         if (last) form_product();
      end
   endtask

   // one transfer on the request side, then update the prediction;
   // tvalid stays up after the transfer until the next idle or pause drops it
   task automatic send_term(logic cmd, logic signed [COEF_W-1:0] coef,
                            logic [EXP_W-1:0] exponent, logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'({exponent, coef});
      req_tuser <= cmd;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
      predict_term(cmd, coef, exponent, last);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_terms.size() != 0) @(posedge clock);
   endtask

   // one polynomial with n terms; exponents drawn from a narrow or wide range
   task automatic send_poly(logic cmd, int n, int exp_max);
      for (int i = 0; i < n; i++)
         send_term(cmd, COEF_W'($urandom), EXP_W'($urandom_range(exp_max)), i == n - 1);
   endtask

   task automatic test_directed();
      // extremes of coefficient and exponent
      send_term(CMD_FIRST, 16'sh7fff, 15'h7fff, 1'b0);
      send_term(CMD_FIRST, 16'sh8000, 15'h0000, 1'b1);
      send_term(CMD_SECOND, 16'sh8000, 15'h7fff, 1'b0);
      send_term(CMD_SECOND, 16'sh7fff, 15'h0000, 1'b1);
      // sums cancelling to zero, equal exponents
      send_term(CMD_FIRST, 16'sd3, 15'd1, 1'b1);
      send_term(CMD_FIRST, -16'sd3, 15'd1, 1'b1);
      send_term(CMD_SECOND, 16'sd5, 15'd2, 1'b1);
      // empty first polynomial: no result
      send_term(CMD_SECOND, 16'sd7, 15'd9, 1'b1);
      wait_drained();
      // store overflow on both sides, all 64 products
      for (int i = 0; i < MAX_TERMS + 1; i++)
         send_term(CMD_FIRST, 16'sh7fff, 15'(i), 1'b0);
      for (int i = 0; i < MAX_TERMS + 1; i++)
         send_term(CMD_SECOND, 16'sh8000, 15'(i * 3), i == MAX_TERMS);
      wait_drained();
   endtask

   task automatic test_random(int products);
      for (int p = 0; p < products; p++) begin
         case ($urandom_range(9))
            0: send_term(1'($urandom), COEF_W'($urandom), EXP_W'($urandom), 1'($urandom));
            1: send_poly(CMD_SECOND, $urandom_range(1, 3), 40);
            default: begin
               send_poly(CMD_FIRST, $urandom_range(1, 9),
                         $urandom_range(1) ? 20 : 32767);
               send_poly(CMD_SECOND, $urandom_range(1, 9),
                         $urandom_range(1) ? 20 : 32767);
            end
         endcase
      end
   endtask

   // receiver blocks while the sender keeps offering
   task automatic test_backpressure();
      holdoff_cycles = 3000;
      send_poly(CMD_FIRST, 8, 100);
      send_poly(CMD_SECOND, 8, 100);
      send_poly(CMD_FIRST, 3, 100);
      send_poly(CMD_SECOND, 3, 100);
      wait_drained();
   endtask

   // receiver side
   always @(posedge clock) begin
      if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      product_term_type want;
      if (reset || !((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         idle_cycles <= reset ? 0 : idle_cycles + 1;
      else
         idle_cycles <= 0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (expected_terms.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = expected_terms.pop_front();
            if (rsp_tdata[SUM_W-1:0] !== want.coef_sum ||
                rsp_tdata[SUM_W+SEXP_W-1:SUM_W] !== want.exp_sum ||
                rsp_tlast !== want.final_term || rsp_tuser !== want.dropped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want coef %0d exp %0d last %b drop %b, got %0d %0d %b %b",
                     want.coef_sum, want.exp_sum, want.final_term, want.dropped,
                     $signed(rsp_tdata[SUM_W-1:0]), rsp_tdata[SUM_W+SEXP_W-1:SUM_W],
                     rsp_tlast, rsp_tuser);
            end
         end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      sender_idle_pct = 31;
      receiver_idle_pct = 70;
      test_random(17);
      test_backpressure();
      sender_idle_pct = 70;
      receiver_idle_pct = 31;
      test_random(17);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random(17);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_terms.size() != 0) mismatch_count++;
      $display("covered %0d input terms, %0d products, %0d result terms",
               item_count, product_count, result_count);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
